/* rtl/cbe_pkg.sv */
// cbe_pkg: shared types and constants of the cubic Bezier easing block.
// No dependencies; imported by the top level and the lerp unit.
package cbe_pkg;

   // Width of the external progress and eased-value fields (Q1.16).
   localparam int IO_FRAC_BITS = 16;
   localparam int IO_WIDTH     = IO_FRAC_BITS + 1;
   localparam int BYTE_BITS    = 8;
   localparam int HALV_WIDTH   = 5;
   localparam int HALV_MAX     = 31;
   localparam int TOL_WIDTH    = 16;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   // Register indexes (byte address / 4).
   localparam logic REG_MATCH_TOL = 1'b0;
   localparam logic [TOL_WIDTH-1:0] MATCH_TOL_RESET = 16'd7;

   // Lerp steps of one de Casteljau evaluation.
   typedef logic [2:0] cbe_step_type;
   localparam cbe_step_type STEP_P1  = 3'd0;
   localparam cbe_step_type STEP_P2  = 3'd1;
   localparam cbe_step_type STEP_P3  = 3'd2;
   localparam cbe_step_type STEP_Q1  = 3'd3;
   localparam cbe_step_type STEP_Q2  = 3'd4;
   localparam cbe_step_type STEP_OUT = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EVAL  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_YEVAL = 5'b01000,
      ST_DONE  = 5'b10000
   } cbe_state_type;

endpackage

/* rtl/cbe_lerp.sv */
// cbe_lerp: shared fixed-point lerp unit, a + floor((b - a) * ct / 2^F).
// Depends on cbe_pkg; one signed multiplier, reused by every curve step.
module cbe_lerp
   import cbe_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic [FRAC_BITS:0] lerp_a,
   input  logic [FRAC_BITS:0] lerp_b,
   input  logic [FRAC_BITS:0] lerp_ct,
   output logic [FRAC_BITS:0] lerp_y
);

   localparam int DW = FRAC_BITS + 2;
   localparam int PW = 2 * FRAC_BITS + 4;

   logic signed [DW-1:0] diff;
   logic signed [DW-1:0] ct_s;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] prod_sh;
   logic signed [DW-1:0] sum;

   // Arithmetic shift of the signed product floors toward minus infinity.
   always_comb begin
      diff    = $signed({1'b0, lerp_b}) - $signed({1'b0, lerp_a});
      ct_s    = $signed({1'b0, lerp_ct});
      prod    = PW'(diff) * PW'(ct_s);
      prod_sh = prod >>> FRAC_BITS;
      sum     = $signed({1'b0, lerp_a}) + prod_sh[DW-1:0];
      lerp_y  = sum[FRAC_BITS:0];
   end

endmodule

/* rtl/cubic_bezier_easing.sv */
// cubic_bezier_easing: top level of the cubic Bezier easing evaluator.
// Depends on cbe_pkg and cbe_lerp (shared lerp unit under a small sequencer).
//
//   channel  direction  handshake               beat contents
//   req_     in         req_valid / req_ready   progress, first_x/y, second_x/y
//   rsp_     out        rsp_valid / rsp_ready   eased_value, converged, halvings_used
//   csr_     in/out     APB psel/penable        match_tolerance at byte address 0
//
// Sequence: each guess is a curve evaluation of six lerps through the one
//   shared multiplier, followed by a compare; k = halvings taken (0..MAX_ITER),
//   then one final evaluation of y.
// Reset: synchronous, active high; clears the sequencer, output valid and the
//   tolerance register (to 7). Payload registers are not reset.
// Stalls: req_ready is high only while idle; a finished result sits in the
//   output register, so the next beat may be taken while it waits. A second
//   result waits in the done state until the output register frees up.
module cubic_bezier_easing
   import cbe_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int MAX_ITER  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [IO_WIDTH-1:0]   req_progress,
   input  logic [BYTE_BITS-1:0]  req_first_x,
   input  logic [BYTE_BITS-1:0]  req_first_y,
   input  logic [BYTE_BITS-1:0]  req_second_x,
   input  logic [BYTE_BITS-1:0]  req_second_y,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IO_WIDTH-1:0]   rsp_eased_value,
   output logic                  rsp_converged,
   output logic [HALV_WIDTH-1:0] rsp_halvings_used,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int W     = FRAC_BITS + 1;
   localparam int IW    = $clog2(MAX_ITER + 1);
   localparam int XW    = 48;
   localparam int SH_UP = (FRAC_BITS >= IO_FRAC_BITS) ? FRAC_BITS - IO_FRAC_BITS : 0;
   localparam int SH_DN = (FRAC_BITS <  IO_FRAC_BITS) ? IO_FRAC_BITS - FRAC_BITS : 0;
   localparam int DCW   = (W > TOL_WIDTH) ? W : TOL_WIDTH;
   localparam logic [W-1:0]        ONE_FX    = W'(1) << FRAC_BITS;
   localparam logic [IO_WIDTH-1:0] IO_ONE    = IO_WIDTH'(1) << IO_FRAC_BITS;
   localparam logic [IW-1:0]       ITER_LAST = IW'(MAX_ITER);

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [TOL_WIDTH-1:0] tol_ff, tol_in;
   logic                 csr_wr, csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_MATCH_TOL);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? CSR_DW'(tol_ff) : '0;

   always_comb begin
      tol_in = tol_ff;
      if (csr_wr && csr_hit) begin
         tol_in = csr_pwdata[TOL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= MATCH_TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer and working registers
   // ---------------------------------------------------------------
   cbe_state_type state_ff, state_in;
   cbe_step_type  step_ff, step_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic          conv_ff, conv_in;

   logic [BYTE_BITS-1:0] xa_ff, xb_ff, ya_ff, yb_ff;
   logic [W-1:0] t_ff, t_in;
   logic [W-1:0] ct_ff, ct_in;
   logic [W-1:0] lo_ff, lo_in;
   logic [W-1:0] hi_ff, hi_in;
   logic [W-1:0] p1_ff, p1_in;
   logic [W-1:0] p2_ff, p2_in;
   logic [W-1:0] p3_ff, p3_in;
   logic [W-1:0] x3_ff, x3_in;
   logic [W-1:0] y_ff, y_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IO_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic                  rsp_conv_ff, rsp_conv_in;
   logic [HALV_WIDTH-1:0] rsp_halv_ff, rsp_halv_in;

   logic                  req_take;
   logic [IO_WIDTH-1:0]   prog_sat;
   logic [XW-1:0]         t_wide, y_wide;
   logic [BYTE_BITS-1:0]  c1_byte, c2_byte;
   logic [W-1:0]          c1, c2;
   logic [W-1:0]          lerp_a, lerp_b, lerp_y;
   logic [DCW-1:0]        x_gap;
   logic [W:0]            mid_sum;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Saturate progress to one, then move it into the internal format.
   always_comb begin
      prog_sat = (req_progress > IO_ONE) ? IO_ONE : req_progress;
      t_wide   = (XW'(prog_sat) << SH_UP) >> SH_DN;
      t_in     = t_wide[W-1:0];
   end

   // Control points of the curve being evaluated: x while searching, y at the end.
   always_comb begin
      c1_byte = (state_ff == ST_YEVAL) ? ya_ff : xa_ff;
      c2_byte = (state_ff == ST_YEVAL) ? yb_ff : xb_ff;
      c1      = W'(c1_byte) << (FRAC_BITS - BYTE_BITS);
      c2      = W'(c2_byte) << (FRAC_BITS - BYTE_BITS);
   end

   // Operand select for the shared lerp unit, one de Casteljau step per cycle.
   always_comb begin
      case (step_ff)
         STEP_P1: begin
            lerp_a = '0;
            lerp_b = c1;
         end
         STEP_P2: begin
            lerp_a = c1;
            lerp_b = c2;
         end
         STEP_P3: begin
            lerp_a = c2;
            lerp_b = ONE_FX;
         end
         STEP_Q1: begin
            lerp_a = p1_ff;
            lerp_b = p2_ff;
         end
         STEP_Q2: begin
            lerp_a = p2_ff;
            lerp_b = p3_ff;
         end
         default: begin
            lerp_a = p1_ff;
            lerp_b = p3_ff;
         end
      endcase
   end

   cbe_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .lerp_a  (lerp_a),
      .lerp_b  (lerp_b),
      .lerp_ct (ct_ff),
      .lerp_y  (lerp_y)
   );

   // Distance between x(ct) and t, widened to meet the tolerance.
   always_comb begin
      if (x3_ff >= t_ff) begin
         x_gap = DCW'(x3_ff - t_ff);
      end else begin
         x_gap = DCW'(t_ff - x3_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      conv_in      = conv_ff;
      ct_in        = ct_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      x3_in        = x3_ff;
      y_in         = y_ff;
      mid_sum      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_conv_in  = rsp_conv_ff;
      rsp_halv_in  = rsp_halv_ff;
      y_wide       = (XW'(y_ff) >> SH_UP) << SH_DN;

      // Write back the lerp result of the current step.
      if (state_ff == ST_EVAL || state_ff == ST_YEVAL) begin
         case (step_ff)
            STEP_P1: p1_in = lerp_y;
            STEP_P2: p2_in = lerp_y;
            STEP_P3: p3_in = lerp_y;
            STEP_Q1: p1_in = lerp_y;
            STEP_Q2: p3_in = lerp_y;
            default: begin
               if (state_ff == ST_EVAL) begin
                  x3_in = lerp_y;
               end else begin
                  y_in = lerp_y;
               end
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ct_in    = t_in;
               lo_in    = '0;
               hi_in    = ONE_FX;
               iter_in  = '0;
               conv_in  = 1'b0;
               step_in  = STEP_P1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (step_ff == STEP_OUT) begin
               state_in = ST_CHECK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_CHECK: begin
            step_in = STEP_P1;
            if (x_gap <= DCW'(tol_ff)) begin
               conv_in  = 1'b1;
               state_in = ST_YEVAL;
            end else if (iter_ff >= ITER_LAST) begin
               state_in = ST_YEVAL;
            end else begin
               // Bisect: keep the half that still holds t.
               if (x3_ff < t_ff) begin
                  lo_in   = ct_ff;
                  mid_sum = {1'b0, ct_ff} + {1'b0, hi_ff};
               end else begin
                  hi_in   = ct_ff;
                  mid_sum = {1'b0, lo_ff} + {1'b0, ct_ff};
               end
               ct_in    = mid_sum[W:1];
               iter_in  = iter_ff + IW'(1);
               state_in = ST_EVAL;
            end
         end
         ST_YEVAL: begin
            if (step_ff == STEP_OUT) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DONE: begin
            // Hold until the output register frees up, then hand the result over.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = y_wide[IO_WIDTH-1:0];
               rsp_conv_in  = conv_ff;
               rsp_halv_in  = (int'(iter_ff) > HALV_MAX) ? HALV_WIDTH'(HALV_MAX)
                                                         : HALV_WIDTH'(iter_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_P1;
         iter_ff      <= '0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         xa_ff <= req_first_x;
         ya_ff <= req_first_y;
         xb_ff <= req_second_x;
         yb_ff <= req_second_y;
         t_ff  <= t_in;
      end
      ct_ff        <= ct_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      p3_ff        <= p3_in;
      x3_ff        <= x3_in;
      y_ff         <= y_in;
      rsp_value_ff <= rsp_value_in;
      rsp_conv_ff  <= rsp_conv_in;
      rsp_halv_ff  <= rsp_halv_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_eased_value   = rsp_value_ff;
   assign rsp_converged     = rsp_conv_ff;
   assign rsp_halvings_used = rsp_halv_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_LAST)
      else $error("halving count above limit");

   a_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL || state_ff == ST_CHECK) |-> (lo_ff <= ct_ff && ct_ff <= hi_ff))
      else $error("guess left the bisection bracket");

   a_noconv_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_conv_ff) |->
         (rsp_halv_ff == ((MAX_ITER > HALV_MAX) ? HALV_WIDTH'(HALV_MAX)
                                                : HALV_WIDTH'(MAX_ITER))))
      else $error("unconverged result before the halving limit");

   a_done_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ($past(state_ff) == ST_YEVAL || $past(state_ff) == ST_DONE))
      else $error("done reached without a y evaluation");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_value_ff) && $stable(rsp_halv_ff)))
      else $error("pending result overwritten");

endmodule
